[design/tidl_pkg.sv]
// Shared types and constants for the tty input line discipline.
package tidl_pkg;

   localparam int BYTE_W   = 8;
   localparam int ROOM_W   = 9;
   localparam int ACTION_W = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 1;

   // Characters handled by the receive translation
   localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_NL = 8'h0A;

   // Action codes on the request word
   localparam logic [ACTION_W-1:0] ACT_RECEIVE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_READ    = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IGNORE_CR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CR_TO_NL  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NL_TO_CR  = 2'd2;

   // Command queue depth between front and back
   localparam int CMDQ_DEPTH = 2;

   typedef enum logic [1:0] {
      OP_RECEIVE,
      OP_READ,
      OP_CLEAR,
      OP_NONE
   } op_type;

   // Classified command handed from front to back
   typedef struct packed {
      op_type            op;
      logic [BYTE_W-1:0] data;   // translated byte
      logic              store;  // 0 for an ignored carriage return
      logic              last;   // final byte of a driver batch
   } cmd_type;

endpackage

[design/tidl_front.sv]
// Front end: accepts request words, holds the config, translates and classifies.
module tidl_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [tidl_pkg::ACTION_W-1:0]     req_action,
   input  logic [tidl_pkg::BYTE_W-1:0]       req_rx_byte,
   input  logic                              req_batch_last,
   input  logic                              csr_write,
   input  logic [tidl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tidl_pkg::CSR_DATA_W-1:0]   csr_data,
   output logic                              push,
   output tidl_pkg::cmd_type                 push_cmd,
   input  logic                              q_full
);
   import tidl_pkg::*;

   logic    ignore_cr_ff, ignore_cr_in;
   logic    cr_to_nl_ff, cr_to_nl_in;
   logic    nl_to_cr_ff, nl_to_cr_in;
   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    accept;

   // Stage stalls only when it holds a word the queue cannot take
   assign req_stall = valid_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign push      = valid_ff && !q_full;
   assign push_cmd  = cmd_ff;

   // Config writes
   always_comb begin
      ignore_cr_in = ignore_cr_ff;
      cr_to_nl_in  = cr_to_nl_ff;
      nl_to_cr_in  = nl_to_cr_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_IGNORE_CR: ignore_cr_in = csr_data[0];
            CSR_CR_TO_NL:  cr_to_nl_in  = csr_data[0];
            CSR_NL_TO_CR:  nl_to_cr_in  = csr_data[0];
            default: ;
         endcase
      end
   end

   // Classify and translate the incoming word
   always_comb begin
      cmd_in.data  = req_rx_byte;
      cmd_in.store = 1'b1;
      cmd_in.last  = req_batch_last;
      if (req_rx_byte == CH_CR) begin
         if (ignore_cr_ff) begin
            cmd_in.store = 1'b0;
         end else if (cr_to_nl_ff) begin
            cmd_in.data = CH_NL;
         end
      end else if (req_rx_byte == CH_NL && nl_to_cr_ff) begin
         cmd_in.data = CH_CR;
      end
      unique case (req_action)
         ACT_RECEIVE: cmd_in.op = OP_RECEIVE;
         ACT_READ:    cmd_in.op = OP_READ;
         ACT_CLEAR:   cmd_in.op = OP_CLEAR;
         default:     cmd_in.op = OP_NONE;
      endcase
   end

   assign valid_in = accept || (valid_ff && !push);

   always_ff @(posedge clock) begin
      if (reset) begin
         ignore_cr_ff <= 1'b0;
         cr_to_nl_ff  <= 1'b0;
         nl_to_cr_ff  <= 1'b0;
         valid_ff     <= 1'b0;
      end else begin
         ignore_cr_ff <= ignore_cr_in;
         cr_to_nl_ff  <= cr_to_nl_in;
         nl_to_cr_ff  <= nl_to_cr_in;
         valid_ff     <= valid_in;
      end
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

[design/tidl_cmdq.sv]
// Short command queue decoupling the front end from the back end.
module tidl_cmdq (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tidl_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output tidl_pkg::cmd_type pop_cmd,
   output logic              empty
);
   import tidl_pkg::*;

   localparam int PW = $clog2(CMDQ_DEPTH);
   localparam int CW = $clog2(CMDQ_DEPTH + 1);

   cmd_type         entries_ff [CMDQ_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full    = (count_ff == CW'(CMDQ_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_cmd = entries_ff[rd_ptr_ff];

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef SYNTH
   // Front never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("cmdq push while full");

   // Back never pops an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("cmdq pop while empty");

   // Count tracks the pointers
   a_count_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == CW'(CMDQ_DEPTH)) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("cmdq count and pointers disagree");
`endif

endmodule

[design/tidl_back.sv]
// Back end: character FIFO storage, batch drop logic and result register.
module tidl_back #(
   parameter int FIFO_DEPTH = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_empty,
   input  tidl_pkg::cmd_type            cmd,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [tidl_pkg::BYTE_W-1:0]  rsp_read_byte,
   output logic                         rsp_read_valid,
   output logic                         rsp_bell,
   output logic [tidl_pkg::ROOM_W-1:0]  rsp_free_room
);
   import tidl_pkg::*;

   localparam int IW = $clog2(FIFO_DEPTH);
   localparam int CW = $clog2(FIFO_DEPTH + 1);

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

   state_type           state_ff, state_in;
   logic [IW-1:0]       head_ff, head_in;
   logic [IW-1:0]       tail_ff, tail_in;
   logic [CW-1:0]       fill_ff, fill_in;
   logic                drop_ff, drop_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]   rsp_byte_ff, rsp_byte_in;
   logic                rsp_rvalid_ff, rsp_rvalid_in;
   logic                rsp_bell_ff, rsp_bell_in;
   logic [ROOM_W-1:0]   rsp_room_ff, rsp_room_in;
   logic                rsp_load;
   logic                out_free;
   logic                fifo_full;
   logic                wr_en;
   logic                rd_en;
   logic [BYTE_W-1:0]   rd_data_ff;
   logic [CW+ROOM_W-1:0] room_wide;
   logic [BYTE_W-1:0]   mem [FIFO_DEPTH];

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fifo_full = (fill_ff == CW'(FIFO_DEPTH));

   // Free room after the step, kept to the low result bits
   assign room_wide = (CW+ROOM_W)'(FIFO_DEPTH) - (CW+ROOM_W)'(fill_in);

   // Command execution
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      fill_in       = fill_ff;
      drop_in       = drop_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_byte_in   = '0;
      rsp_rvalid_in = 1'b0;
      rsp_bell_in   = 1'b0;
      rsp_load      = 1'b0;
      pop           = 1'b0;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty && out_free) begin
               pop = 1'b1;
               case (cmd.op)
                  OP_RECEIVE: begin
                     rsp_load = 1'b1;
                     if (drop_ff) begin
                        if (cmd.last) begin
                           drop_in = 1'b0;
                        end
                     end else if (fifo_full) begin
                        rsp_bell_in = 1'b1;
                        drop_in     = !cmd.last;
                     end else if (cmd.store) begin
                        wr_en   = 1'b1;
                        tail_in = (tail_ff == IW'(FIFO_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
                        fill_in = fill_ff + CW'(1);
                     end
                  end
                  OP_READ: begin
                     if (fill_ff != '0) begin
                        rd_en    = 1'b1;
                        head_in  = (head_ff == IW'(FIFO_DEPTH - 1)) ? '0 : head_ff + 1'b1;
                        fill_in  = fill_ff - CW'(1);
                        state_in = S_READ;
                     end else begin
                        rsp_load = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     rsp_load = 1'b1;
                     head_in  = '0;
                     tail_in  = '0;
                     fill_in  = '0;
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            // popped byte is in the read data register
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_byte_in   = rd_data_ff;
               rsp_rvalid_in = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_room_in = room_wide[ROOM_W-1:0];
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // State and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_load) begin
         rsp_byte_ff   <= rsp_byte_in;
         rsp_rvalid_ff <= rsp_rvalid_in;
         rsp_bell_ff   <= rsp_bell_in;
         rsp_room_ff   <= rsp_room_in;
      end
   end

   // Character store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[tail_ff] <= cmd.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[head_ff];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_byte  = rsp_byte_ff;
   assign rsp_read_valid = rsp_rvalid_ff;
   assign rsp_bell       = rsp_bell_ff;
   assign rsp_free_room  = rsp_room_ff;

`ifndef SYNTH
   // Fill count stays within the store
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(FIFO_DEPTH))
      else $error("fill count beyond depth");

   // Empty or full FIFO has head and tail together
   a_ptr_agree: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0 || fifo_full) |-> head_ff == tail_ff)
      else $error("head and tail disagree with fill count");

   // No new command while a popped byte waits for the result register
   a_read_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |-> !pop)
      else $error("command popped during read completion");
`endif

endmodule

[design/tty_input_line_discipline_unit.sv]
// Receive-side tty line discipline: input FIFO with CR/NL translation.
// An accepted request passes the front-end register, the command queue and the result
// register; a read that pops a byte also passes the store's registered read port. One
// word per cycle while no stall holds the flow; a read that pops a byte holds the back
// end in its read state. Reset clears config, pointers, fill count, drop flag and
// queues; the character store is not cleared and needs no clearing pass.
module tty_input_line_discipline_unit #(
   parameter int FIFO_DEPTH = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [tidl_pkg::ACTION_W-1:0]     req_action,
   input  logic [tidl_pkg::BYTE_W-1:0]       req_rx_byte,
   input  logic                              req_batch_last,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [tidl_pkg::BYTE_W-1:0]       rsp_read_byte,
   output logic                              rsp_read_valid,
   output logic                              rsp_bell,
   output logic [tidl_pkg::ROOM_W-1:0]       rsp_free_room,
   input  logic                              csr_write,
   input  logic [tidl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tidl_pkg::CSR_DATA_W-1:0]   csr_data
);
   import tidl_pkg::*;

   logic    push;
   cmd_type push_cmd;
   logic    q_full;
   logic    q_empty;
   logic    pop;
   cmd_type pop_cmd;

   tidl_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_rx_byte    (req_rx_byte),
      .req_batch_last (req_batch_last),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .push           (push),
      .push_cmd       (push_cmd),
      .q_full         (q_full)
   );

   tidl_cmdq u_cmdq (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .empty    (q_empty)
   );

   tidl_back #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .cmd            (pop_cmd),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_byte  (rsp_read_byte),
      .rsp_read_valid (rsp_read_valid),
      .rsp_bell       (rsp_bell),
      .rsp_free_room  (rsp_free_room)
   );

endmodule

[bench/tidl_reply_checker.sv]
// Response checker for the tty input line discipline: predicts each response and compares it.
module tidl_reply_checker #(
   parameter int DEPTH = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [tidl_pkg::ACTION_W-1:0]     req_action,
   input  logic [tidl_pkg::BYTE_W-1:0]       req_rx_byte,
   input  logic                              req_batch_last,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [tidl_pkg::BYTE_W-1:0]       rsp_read_byte,
   input  logic                              rsp_read_valid,
   input  logic                              rsp_bell,
   input  logic [tidl_pkg::ROOM_W-1:0]       rsp_free_room,
   input  logic                              csr_write,
   input  logic [tidl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tidl_pkg::CSR_DATA_W-1:0]   csr_data,
   output int                                mismatches,
   output int                                pending,
   output int                                checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import tidl_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0] read_byte;
      logic              read_valid;
      logic              bell;
      logic [ROOM_W-1:0] free_room;
   } reply_type;

   // Shadow copy of the character FIFO and the receive controls
   logic [BYTE_W-1:0] char_mem [DEPTH];
   int   rd_ptr;
   int   wr_ptr;
   int   fill_level;
   logic drop_batch;
   logic cfg_ignore_cr;
   logic cfg_cr_to_nl;
   logic cfg_nl_to_cr;

   reply_type expected_replies[$];

   // Apply one request word to the shadow state and return the response it should give
   function automatic reply_type predict_reply(input logic [ACTION_W-1:0] act,
                                               input logic [BYTE_W-1:0]   ch,
                                               input logic                last);
      reply_type r;
      logic [BYTE_W-1:0] stored;
      r = '0;
      case (act)
         ACT_RECEIVE: begin
            if (drop_batch) begin
               // rest of an overrun batch is thrown away quietly
               if (last) drop_batch = 1'b0;
            end else if (fill_level >= DEPTH) begin
               r.bell = 1'b1;
               drop_batch = !last;
            end else if (!(ch == CH_CR && cfg_ignore_cr)) begin
               stored = ch;
               if (ch == CH_CR && cfg_cr_to_nl) stored = CH_NL;
               else if (ch == CH_NL && cfg_nl_to_cr) stored = CH_CR;
               char_mem[wr_ptr] = stored;
               wr_ptr = (wr_ptr + 1 >= DEPTH) ? 0 : wr_ptr + 1;
               fill_level++;
            end
         end
         ACT_READ: begin
            if (fill_level > 0) begin
               r.read_byte  = char_mem[rd_ptr];
               r.read_valid = 1'b1;
               rd_ptr = (rd_ptr + 1 >= DEPTH) ? 0 : rd_ptr + 1;
               fill_level--;
            end
         end
         ACT_CLEAR: begin
            // drop flag survives a clear
            rd_ptr     = 0;
            wr_ptr     = 0;
            fill_level = 0;
         end
         default: ;
      endcase
      r.free_room = ROOM_W'(DEPTH - fill_level);
      return r;
   endfunction

   function automatic int field_differs(input string name,
                                        input logic [ROOM_W-1:0] want,
                                        input logic [ROOM_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h got %0h", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         rd_ptr        = 0;
         wr_ptr        = 0;
         fill_level    = 0;
         drop_batch    = 1'b0;
         cfg_ignore_cr = 1'b0;
         cfg_cr_to_nl  = 1'b0;
         cfg_nl_to_cr  = 1'b0;
         expected_replies.delete();
         mismatches    = 0;
         checked       = 0;
         pending       = 0;
      end else begin
         // register writes
         if (csr_write) begin
            case (csr_index)
               CSR_IGNORE_CR: cfg_ignore_cr = csr_data[0];
               CSR_CR_TO_NL:  cfg_cr_to_nl  = csr_data[0];
               CSR_NL_TO_CR:  cfg_nl_to_cr  = csr_data[0];
               default: ;
            endcase
         end
         // accepted request word
         if (req_valid && !req_stall)
            expected_replies.push_back(predict_reply(req_action, req_rx_byte, req_batch_last));
         // accepted response word
         if (rsp_valid && !rsp_stall) begin
            if (expected_replies.size() == 0) begin
               $display("%0t: unexpected response: byte %h valid %b bell %b room %0d",
                        $time, rsp_read_byte, rsp_read_valid, rsp_bell, rsp_free_room);
               mismatches++;
            end else begin
               want = expected_replies.pop_front();
               mismatches += field_differs("read_byte", ROOM_W'(want.read_byte),
                                           ROOM_W'(rsp_read_byte));
               mismatches += field_differs("read_valid", ROOM_W'(want.read_valid),
                                           ROOM_W'(rsp_read_valid));
               mismatches += field_differs("bell", ROOM_W'(want.bell), ROOM_W'(rsp_bell));
               mismatches += field_differs("free_room", want.free_room, rsp_free_room);
               checked++;
            end
         end
         pending = expected_replies.size();
      end
   end

endmodule

[bench/tb.sv]
// Testbench top for the tty input line discipline: stimulus, idling and the verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tidl_pkg::*;

   localparam int FIFO_DEPTH   = 256;
   localparam int TARGET_WORDS = 1650;
   localparam int STALL_LIMIT  = 2000;
   localparam int LONG_HOLD    = 80;
   localparam int SETTLE       = 8;
   // action code the block leaves unused
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [ACTION_W-1:0]   req_action = ACT_RECEIVE;
   logic [BYTE_W-1:0]     req_rx_byte = '0;
   logic                  req_batch_last = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [BYTE_W-1:0]     rsp_read_byte;
   logic                  rsp_read_valid;
   logic                  rsp_bell;
   logic [ROOM_W-1:0]     rsp_free_room;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_IGNORE_CR;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int   mismatches;
   int   pending;
   int   checked;
   int   words_sent = 0;
   int   settings_used = 0;
   int   quiet_cycles = 0;
   bit   src_idle = 1'b1;
   bit   sink_idle = 1'b1;
   bit   hold_rsp = 1'b0;
   logic cfg_ignore_cr = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   tty_input_line_discipline_unit #(.FIFO_DEPTH(FIFO_DEPTH)) dut (.*);

   tidl_reply_checker #(.DEPTH(FIFO_DEPTH)) u_check (.*);

   // Watchdog: no word moving on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Response side: random stall bursts, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_rsp = 1'b0;
         end else if (sink_idle && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic logic [BYTE_W-1:0] rand_byte();
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   function automatic logic rand_bit();
      return 1'($urandom_range(0, 1));
   endfunction

   // Received characters lean on CR and NL so the translations see plenty of traffic
   function automatic logic [BYTE_W-1:0] pick_char();
      case ($urandom_range(0, 7))
         0, 1:    return CH_CR;
         2:       return CH_NL;
         default: return rand_byte();
      endcase
   endfunction

   // Offer one request word and hold it until it is taken
   task automatic send_word(input logic [ACTION_W-1:0] act,
                            input logic [BYTE_W-1:0]   ch,
                            input logic                last);
      if (src_idle && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= act;
      req_rx_byte    <= ch;
      req_batch_last <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   // Stop offering and wait until every response is back, then let the pipe settle
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_config(input logic ic, input logic cn, input logic nc);
      csr_write <= 1'b1;
      csr_index <= CSR_IGNORE_CR;
      csr_data  <= ic;
      @(posedge clock);
      csr_index <= CSR_CR_TO_NL;
      csr_data  <= cn;
      @(posedge clock);
      csr_index <= CSR_NL_TO_CR;
      csr_data  <= nc;
      @(posedge clock);
      csr_write <= 1'b0;
      cfg_ignore_cr = ic;
      settings_used++;
   endtask

   // Receive batches until the FIFO overflows, then read a little, receive more and clear
   task automatic overrun_phase();
      int left;
      int batch_len;
      logic [BYTE_W-1:0] ch;
      left = FIFO_DEPTH + $urandom_range(8, 40);
      while (left > 0) begin
         batch_len = $urandom_range(1, 48);
         for (int i = 1; i <= batch_len && left > 0; i++) begin
            ch = pick_char();
            send_word(ACT_RECEIVE, ch, i == batch_len);
            // ignored CRs take no room
            if (!(ch == CH_CR && cfg_ignore_cr)) left--;
         end
      end
      // make room while a batch may still be dropping
      repeat ($urandom_range(4, 20)) send_word(ACT_READ, rand_byte(), rand_bit());
      repeat ($urandom_range(4, 20))
         send_word(ACT_RECEIVE, pick_char(), $urandom_range(0, 5) == 0);
      send_word(ACT_CLEAR, rand_byte(), rand_bit());
   endtask

   task automatic mixed_phase(input int n);
      int pick;
      repeat (n) begin
         pick = $urandom_range(0, 99);
         if (pick < 55)      send_word(ACT_RECEIVE, pick_char(), $urandom_range(0, 3) == 0);
         else if (pick < 92) send_word(ACT_READ, rand_byte(), rand_bit());
         else if (pick < 96) send_word(ACT_CLEAR, rand_byte(), rand_bit());
         else                send_word(ACT_UNUSED, rand_byte(), rand_bit());
      end
   endtask

   initial begin
      int combo;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: plain storage, byte extremes, empty reads, unused code, clear
      send_word(ACT_READ, 8'h00, 1'b0);
      send_word(ACT_RECEIVE, 8'h00, 1'b0);
      send_word(ACT_RECEIVE, 8'hFF, 1'b1);
      send_word(ACT_RECEIVE, CH_CR, 1'b0);
      send_word(ACT_RECEIVE, CH_NL, 1'b1);
      send_word(ACT_UNUSED, 8'hA5, 1'b1);
      repeat (5) send_word(ACT_READ, 8'hFF, 1'b1);
      send_word(ACT_RECEIVE, 8'h55, 1'b0);
      send_word(ACT_CLEAR, 8'hFF, 1'b1);
      send_word(ACT_READ, 8'h00, 1'b0);
      drain();

      // CR with both ignore and translate set is dropped
      set_config(1'b1, 1'b1, 1'b0);
      send_word(ACT_RECEIVE, CH_CR, 1'b0);
      send_word(ACT_RECEIVE, CH_NL, 1'b1);
      send_word(ACT_READ, 8'h00, 1'b0);
      send_word(ACT_READ, 8'h00, 1'b0);
      drain();

      // Both translations at once
      set_config(1'b0, 1'b1, 1'b1);
      send_word(ACT_RECEIVE, CH_CR, 1'b0);
      send_word(ACT_RECEIVE, CH_NL, 1'b1);
      send_word(ACT_READ, 8'h00, 1'b0);
      send_word(ACT_READ, 8'h00, 1'b0);

      // Random phases, each under its own register setting
      for (int p = 0; words_sent < TARGET_WORDS; p++) begin
         combo = (p < 8) ? p : $urandom_range(0, 7);
         drain();
         set_config(combo[0], combo[1], combo[2]);
         src_idle  = $urandom_range(0, 3) != 0;
         sink_idle = $urandom_range(0, 3) != 0;
         if (words_sent > TARGET_WORDS - 150) begin
            src_idle  = 1'b0;
            sink_idle = 1'b0;
         end
         if (p == 1 || p == 5) begin
            overrun_phase();
         end else begin
            if (p == 3) begin
               // long response hold-off while requests keep coming
               src_idle = 1'b0;
               hold_rsp = 1'b1;
            end
            mixed_phase($urandom_range(60, 140));
         end
      end
      drain();

      $display("Covered %0d request words, %0d responses checked, %0d register settings,",
               words_sent, checked, settings_used);
      $display("with FIFO overruns, dropped batches, CR/NL translation and a long hold-off.");
      if (mismatches == 0 && pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
